### sv/dfhe_pkg.sv
// ----------------------------------------------------------------------------
// dfhe_pkg
// Types, constants and range tables for the fixed-Huffman token encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dfhe_pkg;

  localparam logic [1:0] CMD_LITERAL = 2'd0;
  localparam logic [1:0] CMD_MATCH   = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;

  localparam logic [7:0]  LIT_LOW_BASE   = 8'h30;
  localparam logic [8:0]  LIT_HIGH_BASE  = 9'h190;
  localparam logic [7:0]  LL_TAIL_BASE   = 8'hC0;
  localparam logic [7:0]  LIT_LOW_LAST   = 8'd143;
  localparam logic [8:0]  LIT_HIGH_FIRST = 9'd144;
  localparam logic [8:0]  EOB_SYM        = 9'd256;
  localparam logic [8:0]  LEN_SYM_FIRST  = 9'd257;
  localparam logic [8:0]  SHORT_SYM_LAST = 9'd279;
  localparam logic [8:0]  TAIL_SYM_FIRST = 9'd280;
  localparam logic [8:0]  LEN_MIN        = 9'd3;
  localparam logic [8:0]  LEN_MAX        = 9'd258;
  localparam logic [15:0] DIST_MIN       = 16'd1;
  localparam logic [15:0] DIST_MAX       = 16'd32768;

  localparam int LEN_RANGES  = 29;
  localparam int DIST_RANGES = 30;

  localparam logic [8:0] LEN_BASE [LEN_RANGES] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };
  localparam logic [2:0] LEN_BITS [LEN_RANGES] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0
  };
  localparam logic [15:0] DIST_BASE [DIST_RANGES] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
    16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
    16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
    16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
  };
  localparam logic [3:0] DIST_BITS [DIST_RANGES] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  literal_byte;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
  } token_t;

  typedef struct packed {
    logic [8:0]  ll_code;
    logic [3:0]  ll_code_len;
    logic [4:0]  len_extra;
    logic [2:0]  len_extra_bits;
    logic [4:0]  dist_code;
    logic [12:0] dist_extra;
    logic [3:0]  dist_extra_bits;
    logic        has_distance;
  } code_t;

  function automatic logic [4:0] len_index(logic [8:0] len);
    logic [4:0] idx;
    idx = '0;
    for (int i = 1; i < LEN_RANGES; i++) begin
      if (len >= LEN_BASE[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [4:0] dist_index(logic [15:0] distance);
    logic [4:0] idx;
    idx = '0;
    for (int i = 1; i < DIST_RANGES; i++) begin
      if (distance >= DIST_BASE[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [4:0] rev5(logic [4:0] v);
    logic [4:0] r;
    for (int k = 0; k < 5; k++) r[k] = v[4-k];
    return r;
  endfunction

  function automatic logic [6:0] rev7(logic [6:0] v);
    logic [6:0] r;
    for (int k = 0; k < 7; k++) r[k] = v[6-k];
    return r;
  endfunction

  function automatic logic [7:0] rev8(logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

  function automatic logic [8:0] rev9(logic [8:0] v);
    logic [8:0] r;
    for (int k = 0; k < 9; k++) r[k] = v[8-k];
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/deflate_fixed_huffman_token_encoder.sv
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_token_encoder
// Maps an LZ77 token to its fixed DEFLATE literal/length code and the
// length/distance extra-bit split.
// Throughput: one token per cycle; three register stages (clamp, range
// search, code/extra build), each stage advances when its successor frees up.
// Reset: synchronous rst empties every stage; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module deflate_fixed_huffman_token_encoder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            tok_valid,
  output logic                 tok_ready,
  input  wire dfhe_pkg::token_t tok,
  output logic                 code_valid,
  input  wire logic            code_ready,
  output dfhe_pkg::code_t      code
);
  import dfhe_pkg::*;

  // stage 1: clamped token
  logic        v1;
  logic [1:0]  s1_cmd;
  logic [7:0]  s1_lit;
  logic [8:0]  s1_len;
  logic [15:0] s1_dist;
  // stage 2: range indexes
  logic        v2;
  logic [1:0]  s2_cmd;
  logic [7:0]  s2_lit;
  logic [8:0]  s2_len;
  logic [15:0] s2_dist;
  logic [4:0]  s2_li;
  logic [4:0]  s2_di;

  logic en1, en2, en3;
  logic [8:0]  len_sat;
  logic [15:0] dist_sat;
  logic [8:0]  sym;
  code_t       code_next;

  assign en3       = !code_valid || code_ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign tok_ready = en1;

  always_comb begin
    len_sat = tok.match_length;
    if (len_sat < LEN_MIN) len_sat = LEN_MIN;
    if (len_sat > LEN_MAX) len_sat = LEN_MAX;
    dist_sat = tok.match_distance;
    if (dist_sat < DIST_MIN) dist_sat = DIST_MIN;
    if (dist_sat > DIST_MAX) dist_sat = DIST_MAX;
  end

  always_comb begin
    code_next = '0;
    sym       = LEN_SYM_FIRST + 9'(s2_li);
    unique case (s2_cmd)
      CMD_LITERAL: begin
        if (s2_lit <= LIT_LOW_LAST) begin
          code_next.ll_code     = {1'b0, rev8(8'(LIT_LOW_BASE + s2_lit))};
          code_next.ll_code_len = 4'd8;
        end else begin
          code_next.ll_code     = rev9(9'(LIT_HIGH_BASE + {1'b0, s2_lit} - LIT_HIGH_FIRST));
          code_next.ll_code_len = 4'd9;
        end
      end
      CMD_MATCH: begin
        if (sym <= SHORT_SYM_LAST) begin
          code_next.ll_code     = {2'b00, rev7(7'(sym - EOB_SYM))};
          code_next.ll_code_len = 4'd7;
        end else begin
          code_next.ll_code = {1'b0,
            rev8(LL_TAIL_BASE + {5'd0, 3'(sym - TAIL_SYM_FIRST)})};
          code_next.ll_code_len = 4'd8;
        end
        code_next.len_extra       = 5'(s2_len - LEN_BASE[s2_li]);
        code_next.len_extra_bits  = LEN_BITS[s2_li];
        code_next.dist_code       = rev5(s2_di);
        code_next.dist_extra      = 13'(s2_dist - DIST_BASE[s2_di]);
        code_next.dist_extra_bits = DIST_BITS[s2_di];
        code_next.has_distance    = 1'b1;
      end
      default: begin
        // end of block, and the unused code treated alike
        code_next.ll_code     = {2'b00, rev7(7'(EOB_SYM - EOB_SYM))};
        code_next.ll_code_len = 4'd7;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      code_valid <= 1'b0;
    end else begin
      if (en1) v1 <= tok_valid;
      if (en2) v2 <= v1;
      if (en3) code_valid <= v2;
    end
    if (en1 && tok_valid) begin
      s1_cmd  <= tok.command;
      s1_lit  <= tok.literal_byte;
      s1_len  <= len_sat;
      s1_dist <= dist_sat;
    end
    if (en2 && v1) begin
      s2_cmd  <= s1_cmd;
      s2_lit  <= s1_lit;
      s2_len  <= s1_len;
      s2_dist <= s1_dist;
      s2_li   <= len_index(s1_len);
      s2_di   <= dist_index(s1_dist);
    end
    if (en3 && v2) begin
      code <= code_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) rst |=> !code_valid)
    else $error("output valid after reset");
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !code_valid |-> tok_ready)
    else $error("input stalled with empty output stage");
  a_match_len: assert property (@(posedge clk) disable iff (rst)
    code_valid && code.has_distance |->
      (code.ll_code_len == 4'd7 || code.ll_code_len == 4'd8) &&
      code.dist_extra_bits <= 4'd13 && code.len_extra_bits <= 3'd5)
    else $error("bad match code lengths");
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code.has_distance |->
      code.len_extra == '0 && code.dist_code == '0 && code.dist_extra == '0 &&
      code.len_extra_bits == '0 && code.dist_extra_bits == '0)
    else $error("extra fields set on literal or end of block");
`endif

endmodule

`default_nettype wire

### verif/tb_deflate_fixed_huffman_token_encoder.sv
// ----------------------------------------------------------------------------
// tb_deflate_fixed_huffman_token_encoder
// Drives literal, match, end-of-block and unused-command tokens into the
// encoder with random idle bursts on both channels. An independent predictor
// computes each token's fixed Huffman code and length/distance extra-bit
// split. Every code beat is checked in order against those expectations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_deflate_fixed_huffman_token_encoder;
  import dfhe_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_TOKENS = 1700;
  localparam int CALM_TAIL = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  localparam int unsigned LEN_START [29] = '{
    3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
    35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258
  };
  localparam int unsigned LEN_EXTRA_W [29] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
    3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0
  };
  localparam int unsigned DIST_START [30] = '{
    1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
    257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145,
    8193, 12289, 16385, 24577
  };
  localparam int unsigned DIST_EXTRA_W [30] = '{
    0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6,
    7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   tok_valid = 1'b0;
  logic   tok_ready;
  token_t tok = '0;
  logic   code_valid;
  logic   code_ready = 1'b0;
  code_t  code;

  token_t token_q [$];
  bit     drain_q [$];
  code_t  pending_codes [$];
  int     tokens_accepted = 0;
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  logic   send_now;
  code_t  want;

  deflate_fixed_huffman_token_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok        (tok),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned flip_bits(int unsigned v, int n);
    int unsigned r;
    r = 0;
    for (int k = 0; k < n; k++) r = (r << 1) | ((v >> k) & 1);
    return r;
  endfunction

  function automatic code_t encode_token(token_t t);
    code_t       c;
    int unsigned sym;
    int unsigned len;
    int unsigned distance;
    int          li;
    int          di;
    c = '0;
    sym = EOB_SYM;
    if (t.command == CMD_LITERAL) begin
      sym = t.literal_byte;
    end else if (t.command == CMD_MATCH) begin
      len = t.match_length;
      distance = t.match_distance;
      if (len < LEN_MIN) len = LEN_MIN;
      if (len > LEN_MAX) len = LEN_MAX;
      if (distance < DIST_MIN) distance = DIST_MIN;
      if (distance > DIST_MAX) distance = DIST_MAX;
      li = 0;
      while (li < 28 && len >= LEN_START[li + 1]) li++;
      di = 0;
      while (di < 29 && distance >= DIST_START[di + 1]) di++;
      sym = LEN_SYM_FIRST + li;
      c.len_extra = 5'(len - LEN_START[li]);
      c.len_extra_bits = 3'(LEN_EXTRA_W[li]);
      c.dist_code = 5'(flip_bits(di, 5));
      c.dist_extra = 13'(distance - DIST_START[di]);
      c.dist_extra_bits = 4'(DIST_EXTRA_W[di]);
      c.has_distance = 1'b1;
    end
    if (sym <= LIT_LOW_LAST) begin
      c.ll_code_len = 4'd8;
      c.ll_code = 9'(flip_bits(LIT_LOW_BASE + sym, 8));
    end else if (sym < EOB_SYM) begin
      c.ll_code_len = 4'd9;
      c.ll_code = 9'(flip_bits(LIT_HIGH_BASE + (sym - LIT_HIGH_FIRST), 9));
    end else if (sym <= SHORT_SYM_LAST) begin
      c.ll_code_len = 4'd7;
      c.ll_code = 9'(flip_bits(sym - EOB_SYM, 7));
    end else begin
      c.ll_code_len = 4'd8;
      c.ll_code = 9'(flip_bits(LL_TAIL_BASE + (sym - TAIL_SYM_FIRST), 8));
    end
    return c;
  endfunction

  function automatic token_t make_token(logic [1:0] cmd, logic [7:0] lit,
                                        logic [8:0] len, logic [15:0] distance);
    token_t t;
    t.command = cmd;
    t.literal_byte = lit;
    t.match_length = len;
    t.match_distance = distance;
    return t;
  endfunction

  function automatic logic [8:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 9'($urandom_range(0, 511));
    if (r < 5) return 9'($urandom_range(3, 12));
    r = $urandom_range(0, 28);
    return 9'(LEN_START[r] + $urandom_range(0, (1 << LEN_EXTRA_W[r]) - 1));
  endfunction

  function automatic logic [15:0] pick_distance();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'($urandom_range(0, 65535));
    if (r == 2) begin
      case ($urandom_range(0, 3))
        0: return 16'd0;
        1: return 16'd32768;
        2: return 16'd32769;
        default: return 16'd65535;
      endcase
    end
    if (r < 5) return 16'($urandom_range(1, 16));
    r = $urandom_range(0, 29);
    return 16'(DIST_START[r] + $urandom_range(0, (1 << DIST_EXTRA_W[r]) - 1));
  endfunction

  function automatic token_t random_token();
    int         r;
    logic [1:0] cmd;
    r = $urandom_range(0, 19);
    if (r < 9) cmd = CMD_LITERAL;
    else if (r < 18) cmd = CMD_MATCH;
    else if (r == 18) cmd = CMD_END;
    else cmd = CMD_UNUSED;
    return make_token(cmd, 8'($urandom_range(0, 255)), pick_length(), pick_distance());
  endfunction

  // no idle bursts near the end, and none in a slice of every 300 beats
  function automatic bit idling_allowed();
    return token_q.size() > CALM_TAIL && (tokens_accepted % 300) >= 60;
  endfunction

  task automatic queue_token(token_t t, bit drain_first);
    token_q.push_back(t);
    drain_q.push_back(drain_first);
  endtask

  initial begin
    queue_token(make_token(CMD_LITERAL, 8'd0, 9'd0, 16'd0), 1'b0);
    queue_token(make_token(CMD_LITERAL, 8'd143, 9'd511, 16'd65535), 1'b0);
    queue_token(make_token(CMD_LITERAL, 8'd144, 9'd258, 16'd32768), 1'b0);
    queue_token(make_token(CMD_LITERAL, 8'd255, 9'd511, 16'd65535), 1'b0);
    queue_token(make_token(CMD_END, 8'd255, 9'd511, 16'd65535), 1'b0);
    queue_token(make_token(CMD_UNUSED, 8'd170, 9'd300, 16'd40000), 1'b0);
    queue_token(make_token(CMD_UNUSED, 8'd0, 9'd0, 16'd0), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd255, 9'd0, 16'd0), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd2, 16'd1), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd85, 9'd3, 16'd2), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd10, 16'd4), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd11, 16'd5), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd130, 16'd256), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd131, 16'd16385), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd227, 16'd24576), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd257, 16'd24577), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd258, 16'd32768), 1'b1);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd259, 16'd32769), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd255, 9'd511, 16'd65535), 1'b0);
    queue_token(make_token(CMD_MATCH, 8'd0, 9'd256, 16'd8192), 1'b0);
    for (int i = 0; i < RANDOM_TOKENS; i++) begin
      queue_token(random_token(), (i % 400) == 200);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (token_q.size() != 0 || tok_valid || pending_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // token driver
  always @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (tok_valid && tok_ready) begin
        pending_codes.push_back(encode_token(tok));
        tokens_accepted++;
      end
      if (!tok_valid || tok_ready) begin
        send_now = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (token_q.size() != 0 &&
                     !(drain_q[0] && pending_codes.size() != 0)) begin
          if (idling_allowed() && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 16);
          end else begin
            send_now = 1'b1;
            tok <= token_q.pop_front();
            void'(drain_q.pop_front());
          end
        end
        tok_valid <= send_now;
      end
    end
  end

  // code monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      code_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (code_valid && code_ready) begin
        if (pending_codes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected code beat %h", code);
          end
        end else begin
          want = pending_codes.pop_front();
          if (code.ll_code !== want.ll_code ||
              code.ll_code_len !== want.ll_code_len ||
              code.len_extra !== want.len_extra ||
              code.len_extra_bits !== want.len_extra_bits ||
              code.dist_code !== want.dist_code ||
              code.dist_extra !== want.dist_extra ||
              code.dist_extra_bits !== want.dist_extra_bits ||
              code.has_distance !== want.has_distance) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display({"code mismatch: exp ll %h/%0d len %0d/%0d dist %h %0d/%0d hd %b,",
                        " got ll %h/%0d len %0d/%0d dist %h %0d/%0d hd %b"},
                       want.ll_code, want.ll_code_len, want.len_extra,
                       want.len_extra_bits, want.dist_code, want.dist_extra,
                       want.dist_extra_bits, want.has_distance,
                       code.ll_code, code.ll_code_len, code.len_extra,
                       code.len_extra_bits, code.dist_code, code.dist_extra,
                       code.dist_extra_bits, code.has_distance);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        code_ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        code_ready <= 1'b0;
      end else begin
        code_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
